/* rtl/rbi_pkg.sv */
`timescale 1ns / 1ps
package rbi_pkg;
	// register map
	localparam int unsigned CFG_TOL = 0;
	localparam int unsigned CFG_LIM = 1;
	localparam int unsigned CFG_IW  = 2;
	localparam int unsigned CFG_DW  = 32;

	localparam logic [30:0] TOL_RST = 31'd26844;
	localparam logic [3:0]  LIM_RST = 4'd10;
	localparam int unsigned DEF_MAX_LEVELS = 10;

	// multiplier: 48x48 magnitudes in 24-bit pieces
	localparam int unsigned MW = 48;
	localparam int unsigned HW = 24;
	localparam int unsigned PW = 96;

	// divider
	localparam int unsigned DVW = 61;	// dividend
	localparam int unsigned DSW = 53;	// divisor
	localparam int unsigned QW  = 58;	// quotient
	localparam int unsigned NBW = 6;	// quotient bit count
	localparam int unsigned SW  = 88;	// shifted divisor
	localparam logic [NBW-1:0] DIV_F_BITS = 6'd33;
	localparam logic [NBW-1:0] DIV_X_BITS = 6'd58;
endpackage

/* rtl/rbi_mul.sv */
`timescale 1ns / 1ps
module rbi_mul import rbi_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [MW-1:0] a,
	input  logic [MW-1:0] b,
	output logic          done,
	output logic [PW-1:0] prod
);
	logic [MW-1:0]   a_q, b_q;
	logic [1:0]      cnt_q;
	logic            run_q, pv_s1, last_s1;
	logic [2*HW-1:0] pp_s1;
	logic [1:0]      psh_s1;
	logic [HW-1:0]   ah, bh;

	assign ah = cnt_q[0] ? a_q[MW-1:HW] : a_q[HW-1:0];
	assign bh = cnt_q[1] ? b_q[MW-1:HW] : b_q[HW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			pv_s1   <= run_q;
			last_s1 <= run_q && (cnt_q == 2'd3);
			done    <= pv_s1 && last_s1;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q  <= a;
			b_q  <= b;
			prod <= '0;
		end else if (pv_s1) begin
			prod <= prod + (PW'(pp_s1) << (psh_s1 * HW));
		end
		pp_s1  <= ah * bh;
		psh_s1 <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
	end
endmodule

/* rtl/rbi_div.sv */
`timescale 1ns / 1ps
module rbi_div import rbi_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [DVW-1:0] dividend,
	input  logic [DSW-1:0] divisor,
	input  logic [NBW-1:0] nbits,
	output logic           done,
	output logic [QW-1:0]  quot
);
	logic [DVW-1:0] rem_q;
	logic [SW-1:0]  dsh_q;
	logic [NBW-1:0] cnt_q;
	logic           run_q, ge;

	assign ge = SW'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - NBW'(1);
				if (cnt_q == NBW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle, top bit first
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= dividend;
			dsh_q <= SW'(divisor) << (nbits - NBW'(1));
			quot  <= '0;
		end else if (run_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q[DVW-1:0];
			quot  <= {quot[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end
endmodule

/* rtl/romberg_integrator_top.sv */
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// input     start / busy             lower_bound, upper_bound (Q12.20)
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
// result    done (one-cycle strobe)  integral (Q4.28), converged, levels_used
//
// One item at a time. Each integrand sample takes a pass through the shared
// multiplier (four 24x24 partial products) for x^2 and a pass through the
// shared restoring divider for 4/(1+x^2), plus the issue and hand-off cycles.
// Up to 2^(L-1)+1 samples for a level limit L, plus one division per
// Richardson step.
// Reset clears control and presets both config registers; no clearing pass.
// Results cannot be stalled; done pulses once per accepted item.
module romberg_integrator_top import rbi_pkg::*; #(
	parameter int unsigned MAX_LEVELS = DEF_MAX_LEVELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] lower_bound,
	input  logic signed [31:0] upper_bound,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data,
	output logic               done,
	output logic signed [31:0] integral,
	output logic               converged,
	output logic [3:0]         levels_used
);
	localparam int unsigned LVW = $clog2(MAX_LEVELS + 1);
	localparam int unsigned IW  = $clog2(MAX_LEVELS);
	localparam int unsigned CW  = MAX_LEVELS - 1;	// midpoint count up to 2^(MAX-2)
	localparam int unsigned RW  = 58;		// row entries, +-2^56 in Q28
	localparam int unsigned XW  = 50;		// sample points, Q35
	localparam int unsigned FRAC_SH = 15;		// Q20 -> Q35
	localparam int unsigned X2_SH   = 42;
	localparam int unsigned MID_SH0 = 21;
	localparam logic [5:0]  TRAP_SH = 6'd23;
	localparam logic [RW-1:0] QLIM  = RW'(1) << 56;
	localparam logic [DSW-1:0] ONE_Q28 = DSW'(1) << 28;
	localparam logic [DVW-1:0] F_NUM  = DVW'(1) << 60;

	// sequencer
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ_GO = 4'd1;
	localparam logic [3:0] ST_SQ_WT = 4'd2;
	localparam logic [3:0] ST_FD_GO = 4'd3;
	localparam logic [3:0] ST_FD_WT = 4'd4;
	localparam logic [3:0] ST_HM_GO = 4'd5;
	localparam logic [3:0] ST_HM_WT = 4'd6;
	localparam logic [3:0] ST_LV    = 4'd7;
	localparam logic [3:0] ST_XD_GO = 4'd8;
	localparam logic [3:0] ST_XD_WT = 4'd9;

	// which samples are being summed
	localparam logic [1:0] PH_F0  = 2'd0;
	localparam logic [1:0] PH_F1  = 2'd1;
	localparam logic [1:0] PH_MID = 2'd2;

	logic [3:0]   state_q;
	logic [1:0]   ph_q;
	logic [30:0]  tol_q;
	logic [3:0]   lim_cfg_q;
	logic [LVW-1:0] lim_q, m_q, k_q;
	logic signed [32:0]   h_q;
	logic signed [31:0]   b_q;
	logic signed [XW-1:0] ax_q, x_q, step_q;
	logic [MW-1:0]  facc_q;
	logic [CW-1:0]  cnt_q;
	logic [DSW-1:0] den_q;
	logic [5:0]     hsh_q;
	logic signed [RW-1:0] p_q;
	logic signed [RW-1:0] row_q [MAX_LEVELS];
	logic           dneg_q;

	// shared units
	logic           mul_go, mul_done, div_go, div_done;
	logic [MW-1:0]  mul_a, mul_b;
	logic [PW-1:0]  prod;
	logic [DVW-1:0] div_n;
	logic [DSW-1:0] div_d;
	logic [NBW-1:0] div_nb;
	logic [QW-1:0]  quot;

	logic signed [XW-1:0] xabs;
	logic signed [32:0]   habs;
	logic [PW-1:0]  x2, hsh;
	logic [RW-1:0]  hmag;
	logic signed [RW-1:0] hval, rk, qv, qn, half;
	logic signed [RW:0]   s2, dd, qsum, qdiff;
	logic [RW:0]    dmag, adiff;
	logic [IW-1:0]  kidx, midx;
	logic [LVW-1:0] m_next;
	logic           conv_n, cont;
	logic [3:0]     lim_c;

	function automatic logic signed [RW-1:0] sat_q(input logic signed [RW:0] v);
		if (v > $signed({1'b0, QLIM}))
			return $signed(QLIM);
		else if (v < -$signed({1'b0, QLIM}))
			return -$signed(QLIM);
		else
			return v[RW-1:0];
	endfunction

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// operand selection for the shared multiplier
	assign xabs  = x_q[XW-1] ? -x_q : x_q;
	assign habs  = h_q[32] ? -h_q : h_q;
	assign mul_go = (state_q == ST_SQ_GO) || (state_q == ST_HM_GO);
	assign mul_a = (state_q == ST_SQ_GO) ? xabs[MW-1:0] : MW'(habs[32:0]);
	assign mul_b = (state_q == ST_SQ_GO) ? xabs[MW-1:0] : facc_q;

	assign x2   = prod >> X2_SH;
	assign hsh  = prod >> hsh_q;
	assign hmag = (hsh > PW'(QLIM)) ? QLIM : hsh[RW-1:0];
	assign hval = h_q[32] ? -$signed(hmag) : $signed(hmag);

	// (row0 + p) / 2 toward zero
	assign s2   = {row_q[0][RW-1], row_q[0]} + {hval[RW-1], hval};
	assign half = sat_q($signed(s2 + {{RW{1'b0}}, s2[RW]}) >>> 1);

	// Richardson step: q = p + (p - row[k-1]) / (4^k - 1)
	assign kidx = IW'(k_q - LVW'(1));
	assign midx = IW'(m_q);
	assign rk   = row_q[kidx];
	assign dd   = {p_q[RW-1], p_q} - {rk[RW-1], rk};
	assign dmag = dd[RW] ? RW'(-dd) : RW'(dd);
	assign qv   = dneg_q ? -$signed(RW'(quot)) : $signed(RW'(quot));
	assign qsum = {p_q[RW-1], p_q} + {qv[RW-1], qv};
	assign qn   = sat_q(qsum);
	assign qdiff = {qn[RW-1], qn} - {p_q[RW-1], p_q};
	assign adiff = qdiff[RW] ? (RW+1)'(-qdiff) : (RW+1)'(qdiff);
	assign conv_n = adiff < (RW+1)'(tol_q);
	assign m_next = m_q + LVW'(1);
	assign cont   = !conv_n && (m_next < lim_q);

	assign div_go = (state_q == ST_FD_GO) || (state_q == ST_XD_GO);
	assign div_n  = (state_q == ST_FD_GO) ? F_NUM : DVW'(dmag);
	assign div_d  = (state_q == ST_FD_GO) ? den_q :
		((DSW'(1) << {k_q, 1'b0}) - DSW'(1));
	assign div_nb = (state_q == ST_FD_GO) ? DIV_F_BITS : DIV_X_BITS;

	// effective level limit, clamped to [2, MAX_LEVELS]
	always_comb begin
		lim_c = lim_cfg_q;
		if (lim_cfg_q < 4'd2)
			lim_c = 4'd2;
		else if (32'(lim_cfg_q) > MAX_LEVELS)
			lim_c = 4'(MAX_LEVELS);
	end

	rbi_mul u_mul (
		.clk, .arst_n, .go(mul_go), .a(mul_a), .b(mul_b), .done(mul_done), .prod
	);

	rbi_div u_div (
		.clk, .arst_n, .go(div_go), .dividend(div_n), .divisor(div_d),
		.nbits(div_nb), .done(div_done), .quot
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= TOL_RST;
			lim_cfg_q <= LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_IW'(CFG_TOL))
				tol_q <= cfg_data[30:0];
			else if (cfg_index == CFG_IW'(CFG_LIM))
				lim_cfg_q <= cfg_data[3:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			ph_q    <= PH_F0;
			m_q     <= '0;
			k_q     <= '0;
			lim_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						ph_q    <= PH_F0;
						lim_q   <= LVW'(lim_c);
						state_q <= ST_SQ_GO;
					end
				end
				ST_SQ_GO: state_q <= ST_SQ_WT;
				ST_SQ_WT: if (mul_done) state_q <= ST_FD_GO;
				ST_FD_GO: state_q <= ST_FD_WT;
				ST_FD_WT: begin
					if (div_done) begin
						case (ph_q)
							PH_F0: begin
								ph_q    <= PH_F1;
								state_q <= ST_SQ_GO;
							end
							PH_F1: state_q <= ST_HM_GO;
							default: begin
								if (cnt_q == CW'(1)) begin
									state_q <= ST_HM_GO;
								end else begin
									cnt_q   <= cnt_q - CW'(1);
									state_q <= ST_SQ_GO;
								end
							end
						endcase
					end
				end
				ST_HM_GO: state_q <= ST_HM_WT;
				ST_HM_WT: begin
					if (mul_done) begin
						if (ph_q == PH_F1) begin
							m_q     <= LVW'(1);
							state_q <= ST_LV;
						end else begin
							k_q     <= LVW'(1);
							state_q <= ST_XD_GO;
						end
					end
				end
				ST_LV: begin
					cnt_q   <= CW'(1) << (m_q - LVW'(1));
					ph_q    <= PH_MID;
					state_q <= ST_SQ_GO;
				end
				ST_XD_GO: state_q <= ST_XD_WT;
				ST_XD_WT: begin
					if (div_done) begin
						if (k_q == m_q) begin
							m_q <= m_next;
							if (cont) begin
								state_q <= ST_LV;
							end else begin
								done    <= 1'b1;
								state_q <= ST_IDLE;
							end
						end else begin
							k_q     <= k_q + LVW'(1);
							state_q <= ST_XD_GO;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					h_q  <= 33'(upper_bound) - 33'(lower_bound);
					b_q  <= upper_bound;
					ax_q <= XW'(lower_bound) <<< FRAC_SH;
					x_q  <= XW'(lower_bound) <<< FRAC_SH;
				end
			end
			ST_SQ_WT: begin
				if (mul_done)
					den_q <= ONE_Q28 + x2[DSW-1:0];
			end
			ST_FD_WT: begin
				if (div_done) begin
					case (ph_q)
						PH_F0: begin
							facc_q <= MW'(quot);
							x_q    <= XW'(b_q) <<< FRAC_SH;
						end
						PH_F1: begin
							facc_q <= facc_q + MW'(quot);
							hsh_q  <= TRAP_SH;
						end
						default: begin
							facc_q <= facc_q + MW'(quot);
							x_q    <= x_q + step_q;
							hsh_q  <= 6'(MID_SH0 + 32'(m_q));
						end
					endcase
				end
			end
			ST_HM_WT: begin
				if (mul_done) begin
					if (ph_q == PH_F1)
						row_q[0] <= hval;
					else
						p_q <= half;
				end
			end
			ST_LV: begin
				// first midpoint at H/2^m, then stride H/2^(m-1)
				x_q    <= ax_q + ((XW'(h_q)) <<< (FRAC_SH - 32'(m_q)));
				step_q <= (XW'(h_q)) <<< (FRAC_SH + 1 - 32'(m_q));
				facc_q <= '0;
			end
			ST_XD_GO: dneg_q <= dd[RW];
			ST_XD_WT: begin
				if (div_done) begin
					row_q[kidx] <= p_q;
					p_q         <= qn;
					if (k_q == m_q) begin
						row_q[midx] <= qn;
						converged   <= conv_n;
						levels_used <= 4'(m_q);
						if (qn > $signed(RW'(32'h7FFF_FFFF)))
							integral <= 32'sh7FFF_FFFF;
						else if (qn < -$signed(RW'(33'h0_8000_0000)))
							integral <= 32'sh8000_0000;
						else
							integral <= qn[31:0];
					end
				end
			end
			default: ;
		endcase
	end
endmodule

/* rtl/rbi_chk.sv */
`timescale 1ns / 1ps
module rbi_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [3:0] levels_used
);
	// an accepted item makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	// a result only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");

	// single result per item
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("repeated result strobe");

	// at least one refinement is always done
	a_levels_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> levels_used != 4'd0) else $error("zero levels reported");
endmodule

bind romberg_integrator_top rbi_chk u_rbi_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.levels_used(levels_used)
);
